// File: rtl/temp_sample_qualifier_ema_assert.svh
// Assertion macros for the temperature sample qualifier checker.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef TEMP_SAMPLE_QUALIFIER_EMA_ASSERT_SVH
`define TEMP_SAMPLE_QUALIFIER_EMA_ASSERT_SVH

// Same-cycle implication, off during reset.
`define TSQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("temp_sample_qualifier_ema: check failed");

// Next-cycle implication, off during reset.
`define TSQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("temp_sample_qualifier_ema: check failed");

`endif

// File: rtl/tsq_pkg.sv
// Shared types and constants for the temperature sample qualifier.
// No dependencies; used by every module of the block.
package tsq_pkg;

    localparam int TICK_COUNT_WIDTH_DEF = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int TEMP_W      = 13;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_EMA_WEIGHT    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_VALID_MIN     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_VALID_MAX     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FAILURE_LIMIT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_LIMIT = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_SEED   = 3'd5;

    localparam logic [8:0]         EMA_WEIGHT_RESET    = 9'd77;
    localparam logic [8:0]         EMA_WEIGHT_FULL     = 9'd256;
    localparam logic signed [12:0] VALID_MIN_RESET     = 13'sd0;
    localparam logic signed [12:0] VALID_MAX_RESET     = 13'sd2400;
    localparam logic [7:0]         FAILURE_LIMIT_RESET = 8'd5;
    localparam logic [15:0]        TIMEOUT_LIMIT_RESET = 16'd1000;
    localparam logic signed [12:0] FILTER_SEED_RESET   = 13'sd320;
    localparam logic [7:0]         FAIL_RUN_MAX        = 8'hFF;

    localparam logic CMD_READING = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    typedef struct packed {
        logic [8:0]         ema_weight;
        logic signed [12:0] valid_min;
        logic signed [12:0] valid_max;
        logic [7:0]         failure_limit;
        logic [15:0]        timeout_limit;
    } cfg_t;

    typedef struct packed {
        logic               cmd;
        logic               read_ok;
        logic signed [12:0] sample_temp;
    } item_t;

    typedef struct packed {
        logic               accepted;
        logic               timed_out;
        logic [7:0]         failure_count;
        logic               sensor_error;
        logic signed [12:0] filtered_temp;
    } result_t;

endpackage

// File: rtl/temp_sample_qualifier_ema.sv
// Temperature sample qualifier with EMA filter: one input word (a reading or
// a tick) gives one result word carrying the filter, error flag, failure run,
// timeout flag and the accept bit. A word goes from the input register through
// the state update into the result register. The block takes one word per
// clock while the receiver keeps up; a result word is offered once it reaches
// the result register, later while the receiver holds off. The rate is set by
// the state update, which reads what the previous word left.
// Depends on tsq_pkg, tsq_cfg and tsq_update.
module temp_sample_qualifier_ema
#(
    parameter int TICK_COUNT_WIDTH = tsq_pkg::TICK_COUNT_WIDTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tsq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tsq_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // read_ok, sample_temp[12:0], 2'b0
    input  logic                            s_tuser,   // cmd
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata    // filtered_temp[12:0], sensor_error,
                                                       // failure_count[7:0], timed_out, accepted
);

    tsq_pkg::cfg_t    cfg;
    tsq_pkg::item_t   item_reg;
    tsq_pkg::result_t res;
    tsq_pkg::result_t out_reg;
    logic             in_valid_reg;
    logic             out_valid_reg;
    logic             advance;
    logic             s_fire;
    logic             m_fire;

    tsq_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tsq_update #(.TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)) u_update
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // Move the held word into the result register when that slot is free.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = out_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            item_reg.cmd         <= s_tuser;
            item_reg.read_ok     <= s_tdata[0];
            item_reg.sample_temp <= $signed(s_tdata[13:1]);
        end
        if (advance)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.accepted, out_reg.timed_out, out_reg.failure_count,
                       out_reg.sensor_error, out_reg.filtered_temp};

endmodule

// File: rtl/tsq_cfg.sv
// Configuration register bank for the temperature sample qualifier.
// Depends on tsq_pkg for register indexes, reset values and cfg_t.
module tsq_cfg
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tsq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tsq_pkg::CFG_DATA_W-1:0]  cfg_data,
    output tsq_pkg::cfg_t                   cfg
);

    tsq_pkg::cfg_t cfg_reg;
    tsq_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                tsq_pkg::REG_EMA_WEIGHT:    cfg_next.ema_weight    = cfg_data[8:0];
                tsq_pkg::REG_VALID_MIN:     cfg_next.valid_min     = $signed(cfg_data[12:0]);
                tsq_pkg::REG_VALID_MAX:     cfg_next.valid_max     = $signed(cfg_data[12:0]);
                tsq_pkg::REG_FAILURE_LIMIT: cfg_next.failure_limit = cfg_data[7:0];
                tsq_pkg::REG_TIMEOUT_LIMIT: cfg_next.timeout_limit = cfg_data[15:0];
                // The seed only loads at reset, and reset restores it, so drop the write.
                tsq_pkg::REG_FILTER_SEED:   cfg_next = cfg_reg;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ema_weight    <= tsq_pkg::EMA_WEIGHT_RESET;
            cfg_reg.valid_min     <= tsq_pkg::VALID_MIN_RESET;
            cfg_reg.valid_max     <= tsq_pkg::VALID_MAX_RESET;
            cfg_reg.failure_limit <= tsq_pkg::FAILURE_LIMIT_RESET;
            cfg_reg.timeout_limit <= tsq_pkg::TIMEOUT_LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/tsq_update.sv
// Qualifier state and its update: window check, failure run,
// EMA filter and idle tick counter. Depends on tsq_pkg.
module tsq_update
#(
    parameter int TICK_COUNT_WIDTH = tsq_pkg::TICK_COUNT_WIDTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  tsq_pkg::item_t   item,
    input  tsq_pkg::cfg_t    cfg,
    output tsq_pkg::result_t res
);

    localparam int CMP_W = (TICK_COUNT_WIDTH > 16) ? TICK_COUNT_WIDTH : 16;

    logic signed [12:0]          filter_reg;
    logic signed [12:0]          filter_next;
    logic [7:0]                  fail_reg;
    logic [7:0]                  fail_next;
    logic                        error_reg;
    logic                        error_next;
    logic [TICK_COUNT_WIDTH-1:0] idle_reg;
    logic [TICK_COUNT_WIDTH-1:0] idle_next;

    logic               in_window;
    logic               good;
    logic [8:0]         weight;
    logic signed [13:0] diff;
    logic signed [23:0] prod;
    logic signed [23:0] rnd;
    logic signed [13:0] delta;
    logic signed [13:0] filter_sum;
    logic [7:0]         fail_inc;
    logic [CMP_W-1:0]   idle_ext;
    logic [CMP_W-1:0]   limit_ext;

    assign in_window = (item.sample_temp >= cfg.valid_min) &&
                       (item.sample_temp <= cfg.valid_max);
    assign good      = (item.cmd == tsq_pkg::CMD_READING) && item.read_ok && in_window;

    // f + round((w * (s - f)) / 256), halves up
    assign weight     = (cfg.ema_weight > tsq_pkg::EMA_WEIGHT_FULL) ?
                        tsq_pkg::EMA_WEIGHT_FULL : cfg.ema_weight;
    assign diff       = {item.sample_temp[12], item.sample_temp} - {filter_reg[12], filter_reg};
    assign prod       = $signed({1'b0, weight}) * diff;
    assign rnd        = prod + 24'sd128;
    assign delta      = rnd[21:8];
    assign filter_sum = {filter_reg[12], filter_reg} + delta;

    assign fail_inc = (fail_reg != tsq_pkg::FAIL_RUN_MAX) ? fail_reg + 8'd1 : fail_reg;

    always_comb
    begin
        filter_next = filter_reg;
        fail_next   = fail_reg;
        error_next  = error_reg;
        idle_next   = idle_reg;
        if (item.cmd == tsq_pkg::CMD_TICK)
        begin
            if (idle_reg != {TICK_COUNT_WIDTH{1'b1}})
            begin
                idle_next = idle_reg + 1'b1;
            end
        end
        else if (good)
        begin
            filter_next = filter_sum[12:0];
            fail_next   = '0;
            error_next  = 1'b0;
            idle_next   = '0;
        end
        else
        begin
            fail_next  = fail_inc;
            error_next = error_reg | (fail_inc >= cfg.failure_limit);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_reg <= tsq_pkg::FILTER_SEED_RESET;
            fail_reg   <= '0;
            error_reg  <= 1'b0;
            idle_reg   <= '0;
        end
        else if (step)
        begin
            filter_reg <= filter_next;
            fail_reg   <= fail_next;
            error_reg  <= error_next;
            idle_reg   <= idle_next;
        end
    end

    assign idle_ext  = CMP_W'(idle_next);
    assign limit_ext = CMP_W'(cfg.timeout_limit);

    assign res.filtered_temp = filter_next;
    assign res.sensor_error  = error_next;
    assign res.failure_count = fail_next;
    assign res.timed_out     = idle_ext > limit_ext;
    assign res.accepted      = good;

endmodule

// File: rtl/temp_sample_qualifier_ema_checker.sv
// Port-level checks for the temperature sample qualifier, bound to the top.
// Depends on temp_sample_qualifier_ema_assert.svh.
`include "temp_sample_qualifier_ema_assert.svh"

module temp_sample_qualifier_ema_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // A stalled result word holds.
    `TSQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // An accepted reading clears the failure run and the error flag.
    `TSQ_ASSERT_NOW(a_accept_clears, m_tvalid && m_tdata[23], m_tdata[21:14] == 8'd0 && !m_tdata[13])
    // An accepted reading restarts the idle count, so no timeout.
    `TSQ_ASSERT_NOW(a_accept_no_timeout, m_tvalid && m_tdata[23], !m_tdata[22])
    // The error flag only stands behind a nonzero failure run.
    `TSQ_ASSERT_NOW(a_error_has_run, m_tvalid && m_tdata[13], m_tdata[21:14] != 8'd0)

endmodule

bind temp_sample_qualifier_ema temp_sample_qualifier_ema_checker u_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/tb.sv
`timescale 1ns / 1ps
// Testbench for temp_sample_qualifier_ema: streams readings and ticks through the block
// and checks each result word against a table for the first directed rows, else a local model.
// Depends on tsq_pkg and the block's RTL.
module tb;
    import tsq_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 300;
    localparam int RANDOM_WORDS   = 1900;
    localparam int DIR_ROWS       = 13;
    localparam int IDLE_W         = TICK_COUNT_WIDTH_DEF;

    // indexes the block does not decode
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

    localparam int MIX_NORMAL   = 0;
    localparam int MIX_READINGS = 1;
    localparam int MIX_TICKS    = 2;

    typedef struct packed {
        logic    known;
        item_t   word;
        result_t want;
    } dir_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [15:0]            s_tdata;    // read_ok, sample_temp[12:0], 2'b0
    logic                   s_tuser;    // cmd
    logic                   m_tvalid;
    logic                   m_tready;
    logic [23:0]            m_tdata;    // filtered_temp[12:0], sensor_error,
                                        // failure_count[7:0], timed_out, accepted

    // model copy of the registers and the qualifier state
    logic [8:0]         mdl_weight;
    logic signed [12:0] mdl_min;
    logic signed [12:0] mdl_max;
    logic [7:0]         mdl_fail_limit;
    logic [15:0]        mdl_timeout;
    logic signed [12:0] mdl_filter;
    logic [7:0]         mdl_fail_run;
    logic               mdl_error;
    logic [IDLE_W-1:0]  mdl_idle;

    result_t pending_results[$];
    logic    row_known;
    result_t row_want;
    int      fails;
    int      idle_cycles;
    int      holds_req;
    int      holds_done;
    int      burst_left;

    temp_sample_qualifier_ema DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic void reset_model();
        mdl_weight     = EMA_WEIGHT_RESET;
        mdl_min        = VALID_MIN_RESET;
        mdl_max        = VALID_MAX_RESET;
        mdl_fail_limit = FAILURE_LIMIT_RESET;
        mdl_timeout    = TIMEOUT_LIMIT_RESET;
        mdl_filter     = FILTER_SEED_RESET;
        mdl_fail_run   = '0;
        mdl_error      = 1'b0;
        mdl_idle       = '0;
    endfunction

    // Advance the model by one word and return the result word it gives.
    function automatic result_t qualify_word(item_t w);
        result_t r;
        int      wgt;
        int      acc;
        r.accepted = 1'b0;
        if (w.cmd == CMD_TICK)
        begin
            if (mdl_idle != '1)
                mdl_idle = mdl_idle + 1'b1;
        end
        else if (!w.read_ok || $signed(w.sample_temp) < mdl_min
                 || $signed(w.sample_temp) > mdl_max)
        begin
            if (mdl_fail_run != FAIL_RUN_MAX)
                mdl_fail_run = mdl_fail_run + 1'b1;
            if (mdl_fail_run >= mdl_fail_limit)
                mdl_error = 1'b1;
        end
        else
        begin
            // weights above full scale take the sample as it is
            wgt = (mdl_weight > EMA_WEIGHT_FULL) ? 256 : int'(mdl_weight);
            acc = wgt * int'($signed(w.sample_temp)) + (256 - wgt) * int'(mdl_filter) + 128;
            acc = acc >>> 8;
            if (acc > 4095)
                acc = 4095;
            if (acc < -4096)
                acc = -4096;
            mdl_filter   = 13'(acc);
            mdl_fail_run = '0;
            mdl_error    = 1'b0;
            mdl_idle     = '0;
            r.accepted   = 1'b1;
        end
        r.filtered_temp = mdl_filter;
        r.sensor_error  = mdl_error;
        r.failure_count = mdl_fail_run;
        r.timed_out     = (mdl_idle > mdl_timeout);
        return r;
    endfunction

    function automatic dir_row_t row(logic known, logic cmd, logic ok, int smp,
                                     int filt, int cnt, logic err);
        dir_row_t r;
        r.known                = known;
        r.word.cmd             = cmd;
        r.word.read_ok         = ok;
        r.word.sample_temp     = 13'(smp);
        r.want.filtered_temp   = 13'(filt);
        r.want.sensor_error    = err;
        r.want.failure_count   = 8'(cnt);
        r.want.timed_out       = 1'b0;
        r.want.accepted        = 1'b0;
        return r;
    endfunction

    function automatic item_t make_item(int mix);
        item_t w;
        int    pick;
        int    span;
        w.cmd         = CMD_READING;
        w.read_ok     = 1'b1;
        w.sample_temp = 13'($urandom_range(0, 8191));
        pick          = $urandom_range(0, 99);
        if (mix == MIX_TICKS || (mix == MIX_NORMAL && pick < 30))
        begin
            w.cmd     = CMD_TICK;
            w.read_ok = 1'($urandom_range(0, 1));
        end
        else if (pick < 42)
            w.read_ok = 1'b0;
        else if (pick >= 55 && mdl_min <= mdl_max)
        begin
            // land inside the window so the filter moves
            span          = int'(mdl_max) - int'(mdl_min);
            w.sample_temp = 13'(int'(mdl_min) + int'($urandom_range(0, span)));
        end
        return w;
    endfunction

    task automatic set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_EMA_WEIGHT:    mdl_weight     = val[8:0];
            REG_VALID_MIN:     mdl_min        = val[12:0];
            REG_VALID_MAX:     mdl_max        = val[12:0];
            REG_FAILURE_LIMIT: mdl_fail_limit = val[7:0];
            REG_TIMEOUT_LIMIT: mdl_timeout    = val[15:0];
            // the seed only loads at reset
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic send_word(item_t w);
        s_tvalid <= 1'b1;
        s_tuser  <= w.cmd;
        s_tdata  <= {2'b00, w.sample_temp, w.read_ok};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Bursts of random length with random gaps; some bursts run back to back.
    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            fails++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Predict each word the block takes.
    always @(posedge clk)
    begin : take_word
        item_t   w;
        result_t r;
        if (rst_n && s_tvalid && s_tready)
        begin
            w.cmd         = s_tuser;
            w.read_ok     = s_tdata[0];
            w.sample_temp = s_tdata[13:1];
            r = qualify_word(w);
            if (row_known)
                r = row_want;
            pending_results.push_back(r);
        end
    end

    always @(posedge clk)
    begin : take_result
        result_t want;
        result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata);
            if (pending_results.size() == 0)
            begin
                fails++;
                $display("%0t: unexpected result word, expected none, got %h",
                         $time, m_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("filtered_temp", int'($signed(want.filtered_temp)),
                            int'($signed(got.filtered_temp)));
                check_field("sensor_error", want.sensor_error, got.sensor_error);
                check_field("failure_count", want.failure_count, got.failure_count);
                check_field("timed_out", want.timed_out, got.timed_out);
                check_field("accepted", want.accepted, got.accepted);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Receiver: segments of steady, random or mostly stalled ready, plus long holds on request.
    initial
    begin : receiver
        int seg;
        int mode;
        seg      = 0;
        mode     = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_done < holds_req)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                holds_done++;
            end
            if (seg == 0)
            begin
                seg  = $urandom_range(8, 60);
                mode = $urandom_range(0, 2);
            end
            seg--;
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial
    begin : stimulus
        dir_row_t dir_tab [DIR_ROWS];
        int       ph;
        int       i;
        int       n;
        int       sent;
        int       mix;
        int       wt;
        int       lo;
        int       hi;
        int       fl;
        int       tl;
        int       sd;
        logic [31:0] junk;
        logic [CFG_INDEX_W-1:0] spare;

        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        row_known   = 1'b0;
        row_want    = '0;
        holds_req   = 0;
        burst_left  = 0;
        reset_model();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset registers: weight 77, window 0..2400, limit 5, timeout 1000, seed 320
        dir_tab[0]  = row(1'b1, CMD_TICK,    1'b0, 0,     320, 0, 1'b0);
        dir_tab[1]  = row(1'b1, CMD_READING, 1'b0, 100,   320, 1, 1'b0);
        dir_tab[2]  = row(1'b1, CMD_READING, 1'b1, -1024, 320, 2, 1'b0);
        dir_tab[3]  = row(1'b1, CMD_READING, 1'b1, 4095,  320, 3, 1'b0);
        dir_tab[4]  = row(1'b1, CMD_READING, 1'b1, -4096, 320, 4, 1'b0);
        dir_tab[5]  = row(1'b1, CMD_READING, 1'b1, 2401,  320, 5, 1'b1);
        dir_tab[6]  = row(1'b1, CMD_READING, 1'b1, -1,    320, 6, 1'b1);
        dir_tab[7]  = row(1'b0, CMD_READING, 1'b1, 0,     0,   0, 1'b0);
        dir_tab[8]  = row(1'b0, CMD_READING, 1'b1, 2400,  0,   0, 1'b0);
        dir_tab[9]  = row(1'b0, CMD_TICK,    1'b1, -1,    0,   0, 1'b0);
        dir_tab[10] = row(1'b0, CMD_READING, 1'b1, 1234,  0,   0, 1'b0);
        dir_tab[11] = row(1'b0, CMD_READING, 1'b0, 0,     0,   0, 1'b0);
        dir_tab[12] = row(1'b0, CMD_READING, 1'b1, 1,     0,   0, 1'b0);

        for (i = 0; i < DIR_ROWS; i++)
        begin
            row_known = dir_tab[i].known;
            row_want  = dir_tab[i].want;
            send_word(dir_tab[i].word);
        end
        row_known = 1'b0;

        ph   = 0;
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            drain_results();
            wt  = ($urandom_range(0, 7) == 0) ? 511 : $urandom_range(0, 300);
            lo  = $urandom_range(0, 5119) - 1024;
            hi  = $urandom_range(0, 5119) - 1024;
            if (lo > hi && $urandom_range(0, 9) != 0)
            begin
                sd = lo;
                lo = hi;
                hi = sd;
            end
            fl  = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 8) : $urandom_range(0, 255);
            tl  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 65535);
            sd  = $urandom_range(0, 8191);
            n   = $urandom_range(40, 120);
            mix = MIX_NORMAL;
            spare = ($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B;
            case (ph)
                0:
                begin
                    wt = 0;
                    lo = -4096;
                    hi = 4095;
                    fl = 1;
                    tl = 0;
                end
                1:
                begin
                    wt = 256;
                    lo = -1024;
                    hi = 4095;
                    fl = 0;
                    tl = 1;
                end
                2:
                begin
                    wt    = 511;
                    fl    = 255;
                    tl    = 65535;
                    sd    = 4095;
                    spare = REG_SPARE_A;
                end
                3:
                begin
                    // empty window: drive the failure run into saturation
                    lo  = 100;
                    hi  = 99;
                    fl  = 255;
                    n   = 300;
                    mix = MIX_READINGS;
                end
                4:
                begin
                    wt    = 1;
                    lo    = 500;
                    hi    = 500;
                    fl    = 2;
                    tl    = 3;
                    sd    = -4096;
                    spare = REG_SPARE_B;
                end
                6:
                begin
                    // ticks only, back to back: run the idle counter well past the limit
                    lo  = 0;
                    hi  = 2400;
                    tl  = 20;
                    n   = 60;
                    mix = MIX_TICKS;
                end
                default: ;
            endcase

            junk = $urandom;
            set_reg(REG_EMA_WEIGHT,    {junk[6:0], 9'(wt)});
            set_reg(REG_VALID_MIN,     {junk[9:7], 13'(lo)});
            set_reg(REG_VALID_MAX,     {junk[12:10], 13'(hi)});
            set_reg(REG_FAILURE_LIMIT, {junk[20:13], 8'(fl)});
            set_reg(REG_TIMEOUT_LIMIT, 16'(tl));
            if (ph == 2 || ph == 4 || junk[21])
                set_reg(REG_FILTER_SEED, {junk[24:22], 13'(sd)});
            if (ph == 2 || ph == 4 || junk[25])
                set_reg(spare, junk[31:16]);
            cfg_we <= 1'b0;

            for (i = 0; i < n; i++)
            begin
                if (mix != MIX_TICKS)
                    pace();
                // let the block back up against a stalled receiver
                if (ph == 5 && i == 10)
                    holds_req++;
                send_word(make_item(mix));
            end
            if (mix != MIX_TICKS)
                sent += n;
            ph++;
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (fails == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/tsq_pkg.sv
rtl/tsq_cfg.sv
rtl/tsq_update.sv
rtl/temp_sample_qualifier_ema.sv
rtl/temp_sample_qualifier_ema_checker.sv
tb/tb.sv
